// File: sv/line_error_gain_supervisor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line error gain supervisor
// Shared concurrent check macros. Defining NO_ASSERTIONS removes all checks.
// ----------------------------------------------------------------------------
`ifndef LINE_ERROR_GAIN_SUPERVISOR_ASSERT_SVH
`define LINE_ERROR_GAIN_SUPERVISOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that is switched off while reset is held.
`define LGES_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("line_error_gain_supervisor: check failed");

// Check that also runs during reset.
`define LGES_ASSERT_RESET(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("line_error_gain_supervisor: reset check failed");

`else

`define LGES_ASSERT(name, clk, rst_n, prop)
`define LGES_ASSERT_RESET(name, clk, prop)

`endif

`endif

// File: sv/lges_pkg.sv
// ----------------------------------------------------------------------------
// Line error gain supervisor package
// Shared field widths, payload type, condition codes and step helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lges_pkg;

    // Field widths of the stream payload.
    localparam int BRIGHT_W = 7;
    localparam int ERR_W    = 8;
    localparam int SPEED_W  = 18;
    localparam int GAIN_W   = 21;

    // Width used while stepping and saturating a speed or gain.
    localparam int ADJ_W = 23;

    localparam int SPEED_LIM = 100000;
    localparam int GAIN_LIM  = 1000000;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_TARGET_BRIGHTNESS = 3'd0,
        REG_TARGET_SPEED      = 3'd1,
        REG_TARGET_KP         = 3'd2,
        REG_TARGET_KI         = 3'd3,
        REG_TARGET_KD         = 3'd4,
        REG_STABLE_LIMIT      = 3'd5,
        REG_ZIGZAG_MARGIN     = 3'd6,
        REG_OUT_MARGIN        = 3'd7
    } cfg_reg_t;

    // Classification of one sample.
    typedef enum logic [1:0] {
        COND_ZIGZAG     = 2'd0,
        COND_OFF_COURSE = 2'd1,
        COND_STABLE     = 2'd2,
        COND_UNKNOWN    = 2'd3
    } cond_t;

    // Speed and gains that travel with each sample.
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
    } gains_t;

    typedef logic signed [ADJ_W-1:0] adj_t;

    // One step of cur toward tgt; the step may pass the target.
    function automatic adj_t toward(adj_t cur, adj_t tgt, adj_t step);
        adj_t res;
        if (cur < tgt) begin
            res = cur + step;
        end else if (cur > tgt) begin
            res = cur - step;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // Clamp v to the range -lim to lim.
    function automatic adj_t saturate(adj_t v, adj_t lim);
        adj_t res;
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/lges_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module lges_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 150
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/lges_window.sv
// ----------------------------------------------------------------------------
// Error ring and running window sums
// Stores brightness errors in a ring and keeps long and short window sums.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_error_gain_supervisor_assert.svh"

module lges_window
    import lges_pkg::*;
#(
    parameter int LONG_WINDOW  = 150,
    parameter int SHORT_WINDOW = 25
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [BRIGHT_W-1:0]   target_brightness,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BRIGHT_W-1:0]   in_brightness,
    input  wire gains_t                in_gains,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gains_t                     out_gains,
    output logic signed [$clog2(LONG_WINDOW*127+1):0] out_ls,
    output logic [$clog2(LONG_WINDOW*127+1)-1:0]      out_la,
    output logic signed [$clog2(((SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW :
                                 SHORT_WINDOW)*127+1):0] out_ss,
    output logic [$clog2(((SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW :
                          SHORT_WINDOW)*127+1)-1:0] out_sa
);

    localparam int N_EFF  = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
    localparam int AW     = $clog2(LONG_WINDOW);
    localparam int FILL_W = $clog2(LONG_WINDOW + 1);
    localparam int LA_W   = $clog2(LONG_WINDOW*127+1);
    localparam int LS_W   = LA_W + 1;
    localparam int SA_W   = $clog2(N_EFF*127+1);
    localparam int SS_W   = SA_W + 1;
    localparam int MAG_W  = ERR_W - 1;

    // Pointer and fill state.
    logic [AW-1:0]      wp_reg;
    logic [FILL_W-1:0]  fill_reg;

    // Running sums, kept exact from the first sample on.
    logic signed [LS_W-1:0] ls_reg, ls_next;
    logic [LA_W-1:0]        la_reg, la_next;
    logic signed [SS_W-1:0] ss_reg, ss_next;
    logic [SA_W-1:0]        sa_reg, sa_next;

    // Stage 1: ring read in flight.
    logic                    p1_valid_reg;
    logic signed [ERR_W-1:0] p1_err_reg;
    logic                    p1_lok_reg;
    logic                    p1_sok_reg;
    logic                    p1_full_reg;
    gains_t                  p1_gains_reg;

    // Stage 2: sums of this sample.
    logic                   p2_valid_reg;
    logic signed [LS_W-1:0] p2_ls_reg;
    logic [LA_W-1:0]        p2_la_reg;
    logic signed [SS_W-1:0] p2_ss_reg;
    logic [SA_W-1:0]        p2_sa_reg;
    gains_t                 p2_gains_reg;

    logic                    p1_free, p2_free, accept, p1_go;
    logic signed [ERR_W-1:0] err;
    logic [AW-1:0]           short_addr;
    logic                    fill_full;
    logic [ERR_W-1:0]        rd_long, rd_short;
    logic signed [ERR_W-1:0] rd_long_s, rd_short_s;
    logic [MAG_W-1:0]        mag_err, mag_long, mag_short;
    logic signed [LS_W-1:0]  ls_leave;
    logic [LA_W-1:0]         la_leave;
    logic signed [SS_W-1:0]  ss_leave;
    logic [SA_W-1:0]         sa_leave;
    logic [LS_W-1:0]         ls_mag;
    logic [SS_W-1:0]         ss_mag;

    // Pipeline flow control: a stage loads when it is empty or moves on.
    assign p2_free  = !p2_valid_reg || out_ready;
    assign p1_free  = !p1_valid_reg || p2_free;
    assign in_ready = p1_free;
    assign accept   = in_valid && p1_free;
    assign p1_go    = p1_valid_reg && p2_free;

    // Error against the set point and the addresses of the leaving entries.
    assign err       = ERR_W'({1'b0, in_brightness}) - ERR_W'({1'b0, target_brightness});
    assign fill_full = (fill_reg == FILL_W'(LONG_WINDOW));

    always_comb begin
        if ({1'b0, wp_reg} >= (AW+1)'(N_EFF)) begin
            short_addr = AW'({1'b0, wp_reg} - (AW+1)'(N_EFF));
        end else begin
            short_addr = AW'({1'b0, wp_reg} + (AW+1)'(LONG_WINDOW - N_EFF));
        end
    end

    // Two copies of the ring, one read port each.
    lges_ram #(
        .WIDTH (ERR_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring_long (
        .clk   (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (err),
        .re    (accept),
        .raddr (wp_reg),
        .rdata (rd_long)
    );

    lges_ram #(
        .WIDTH (ERR_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring_short (
        .clk   (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (err),
        .re    (accept),
        .raddr (short_addr),
        .rdata (rd_short)
    );

    // Pointer advances on every transfer; the fill count advances until the ring is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (accept) begin
            wp_reg <= (wp_reg == AW'(LONG_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
            if (!fill_full) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // Stage 1 register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_free) begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_err_reg   <= err;
            p1_lok_reg   <= fill_full;
            p1_sok_reg   <= (fill_reg >= FILL_W'(N_EFF));
            p1_full_reg  <= fill_full;
            p1_gains_reg <= in_gains;
        end
    end

    // Magnitudes of the entering and leaving errors.
    assign rd_long_s  = rd_long;
    assign rd_short_s = rd_short;
    assign mag_err    = p1_err_reg[ERR_W-1] ? MAG_W'(-p1_err_reg) : MAG_W'(p1_err_reg);
    assign mag_long   = rd_long_s[ERR_W-1] ? MAG_W'(-rd_long_s) : MAG_W'(rd_long_s);
    assign mag_short  = rd_short_s[ERR_W-1] ? MAG_W'(-rd_short_s) : MAG_W'(rd_short_s);

    // An entry leaves a window only once it has been written.
    assign ls_leave = p1_lok_reg ? LS_W'(rd_long_s) : '0;
    assign la_leave = p1_lok_reg ? LA_W'(mag_long) : '0;
    assign ss_leave = p1_sok_reg ? SS_W'(rd_short_s) : '0;
    assign sa_leave = p1_sok_reg ? SA_W'(mag_short) : '0;

    assign ls_next = ls_reg + LS_W'(p1_err_reg) - ls_leave;
    assign la_next = la_reg + LA_W'(mag_err) - la_leave;
    assign ss_next = ss_reg + SS_W'(p1_err_reg) - ss_leave;
    assign sa_next = sa_reg + SA_W'(mag_err) - sa_leave;

    // Running sums update as a sample leaves stage 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ls_reg <= '0;
            la_reg <= '0;
            ss_reg <= '0;
            sa_reg <= '0;
        end else if (p1_go) begin
            ls_reg <= ls_next;
            la_reg <= la_next;
            ss_reg <= ss_next;
            sa_reg <= sa_next;
        end
    end

    // Stage 2 register; the sums read as zero until the ring has been full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_free) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_go) begin
            p2_ls_reg    <= p1_full_reg ? ls_next : '0;
            p2_la_reg    <= p1_full_reg ? la_next : '0;
            p2_ss_reg    <= p1_full_reg ? ss_next : '0;
            p2_sa_reg    <= p1_full_reg ? sa_next : '0;
            p2_gains_reg <= p1_gains_reg;
        end
    end

    assign out_valid = p2_valid_reg;
    assign out_gains = p2_gains_reg;
    assign out_ls    = p2_ls_reg;
    assign out_la    = p2_la_reg;
    assign out_ss    = p2_ss_reg;
    assign out_sa    = p2_sa_reg;

    // Magnitudes of the signed sums, for the checks below.
    assign ls_mag = ls_reg[LS_W-1] ? LS_W'(-ls_reg) : LS_W'(ls_reg);
    assign ss_mag = ss_reg[SS_W-1] ? SS_W'(-ss_reg) : SS_W'(ss_reg);

    // During warm-up the write pointer equals the number of samples taken.
    `LGES_ASSERT(a_wp_follows_fill, aclk, aresetn, (!fill_full |-> (wp_reg == AW'(fill_reg))))
    // A signed sum never exceeds the absolute sum over the same entries.
    `LGES_ASSERT(a_sum_bound, aclk, aresetn, ((ls_mag <= LS_W'(la_reg)) && (ss_mag <= SS_W'(sa_reg))))
    // A transfer always lands in stage 1 with its ring read.
    `LGES_ASSERT(a_accept_loads, aclk, aresetn, (accept |=> p1_valid_reg))

endmodule

`default_nettype wire

// File: sv/line_error_gain_supervisor.sv
// ----------------------------------------------------------------------------
// Line error gain supervisor
// Classifies brightness error history and steps speed and PID gains.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_ channel, one transfer per sample, carrying a
//   brightness reading and the current speed and PID gains. Each sample
//   yields exactly one result on the m_ channel with the adjusted speed,
//   the adjusted gains and the condition code.
//   Targets and thresholds are set through the cfg_ write port while no
//   sample is in flight; a write takes effect at the clock edge it is seen.
//   The result passes through the ring-read stage, the window-sum stage, the
//   condition stage and the output register before m_tvalid rises.
//   Throughput is one sample per clock while m_tready does not stall: the ring is held in two RAM copies,
//   so the entries leaving the long and the short window are read in the
//   same cycle, and the running sums update once per sample.
//   Reset clears pointers, fill count, sums and pipeline valids at once;
//   there is no clearing pass over the ring. The first LONG_WINDOW samples
//   see all window sums as zero.
//   When the receiver stalls, the result holds on m_tdata and the internal
//   stages keep filling; s_tready drops once all stages hold a sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_error_gain_supervisor_assert.svh"

module line_error_gain_supervisor
    import lges_pkg::*;
#(
    parameter int LONG_WINDOW  = 150,
    parameter int SHORT_WINDOW = 25,
    parameter int SPEED_STEP   = 1,
    parameter int P_STEP       = 1,
    parameter int I_STEP       = 1,
    parameter int D_STEP       = 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_wdata,
    // Sample channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: brightness[6:0], speed_now[24:7], kp_now[45:25],
    //          ki_now[66:46], kd_now[87:67]
    input  wire logic [87:0] s_tdata,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: speed_new[17:0], kp_new[38:18], ki_new[59:39],
    //          kd_new[80:60], condition[82:81], zero[87:83]
    output logic [87:0]      m_tdata
);

    localparam int N_EFF = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
    localparam int LA_W  = $clog2(LONG_WINDOW*127+1);
    localparam int LS_W  = LA_W + 1;
    localparam int SA_W  = $clog2(N_EFF*127+1);
    localparam int SS_W  = SA_W + 1;
    localparam int LW    = (LA_W > 14) ? LA_W : 14;
    localparam int ZW    = LW + 1;
    localparam int OW    = ((SA_W > 12) ? SA_W : 12) + 2;

    // Configuration registers.
    logic [BRIGHT_W-1:0]       target_brightness_reg;
    logic signed [SPEED_W-1:0] target_speed_reg;
    logic [19:0]               target_kp_reg;
    logic [19:0]               target_ki_reg;
    logic [19:0]               target_kd_reg;
    logic [13:0]               stable_limit_reg;
    logic [13:0]               zigzag_margin_reg;
    logic [11:0]               out_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_brightness_reg <= BRIGHT_W'(50);
            target_speed_reg      <= SPEED_W'(50000);
            target_kp_reg         <= 20'd10000;
            target_ki_reg         <= 20'd0;
            target_kd_reg         <= 20'd0;
            stable_limit_reg      <= 14'd300;
            zigzag_margin_reg     <= 14'd75;
            out_margin_reg        <= 12'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_BRIGHTNESS: target_brightness_reg <= cfg_wdata[BRIGHT_W-1:0];
                REG_TARGET_SPEED:      target_speed_reg      <= cfg_wdata[SPEED_W-1:0];
                REG_TARGET_KP:         target_kp_reg         <= cfg_wdata;
                REG_TARGET_KI:         target_ki_reg         <= cfg_wdata;
                REG_TARGET_KD:         target_kd_reg         <= cfg_wdata;
                REG_STABLE_LIMIT:      stable_limit_reg      <= cfg_wdata[13:0];
                REG_ZIGZAG_MARGIN:     zigzag_margin_reg     <= cfg_wdata[13:0];
                REG_OUT_MARGIN:        out_margin_reg        <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Unpack the input transfer.
    gains_t in_gains;

    assign in_gains.speed = s_tdata[24:7];
    assign in_gains.kp    = s_tdata[45:25];
    assign in_gains.ki    = s_tdata[66:46];
    assign in_gains.kd    = s_tdata[87:67];

    // Flow control of the two back stages.
    logic m_valid_reg;
    logic c_valid_reg;
    logic out_free, c_free, c_blocked;

    assign out_free  = !m_valid_reg || m_tready;
    assign c_free    = !c_valid_reg || out_free;
    assign c_blocked = c_valid_reg && !out_free;

    // Ring and window sums.
    logic                   w_valid;
    gains_t                 w_gains;
    logic signed [LS_W-1:0] w_ls;
    logic [LA_W-1:0]        w_la;
    logic signed [SS_W-1:0] w_ss;
    logic [SA_W-1:0]        w_sa;

    lges_window #(
        .LONG_WINDOW  (LONG_WINDOW),
        .SHORT_WINDOW (SHORT_WINDOW)
    ) u_window (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .target_brightness (target_brightness_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_brightness     (s_tdata[6:0]),
        .in_gains          (in_gains),
        .out_valid         (w_valid),
        .out_ready         (c_free),
        .out_gains         (w_gains),
        .out_ls            (w_ls),
        .out_la            (w_la),
        .out_ss            (w_ss),
        .out_sa            (w_sa)
    );

    // Classification tests on the window sums.
    logic [LA_W-1:0]      ls_abs;
    logic [SA_W-1:0]      ss_abs;
    logic signed [OW-1:0] ms_s, sa_s, om_s, lo_bound, hi_bound;
    logic                 zig_hit, off_hit, stab_hit;
    cond_t                cond;

    assign ls_abs   = w_ls[LS_W-1] ? LA_W'(-w_ls) : LA_W'(w_ls);
    assign ss_abs   = w_ss[SS_W-1] ? SA_W'(-w_ss) : SA_W'(w_ss);
    assign zig_hit  = (ZW'(ls_abs) + ZW'(zigzag_margin_reg)) < ZW'(w_la);
    assign ms_s     = OW'(ss_abs);
    assign sa_s     = OW'(w_sa);
    assign om_s     = OW'(out_margin_reg);
    assign lo_bound = sa_s - om_s;
    assign hi_bound = sa_s + om_s;
    assign off_hit  = (lo_bound < ms_s) && (ms_s < hi_bound);
    assign stab_hit = LW'(w_la) <= LW'(stable_limit_reg);

    // The first test that holds wins.
    always_comb begin
        if (zig_hit) begin
            cond = COND_ZIGZAG;
        end else if (off_hit) begin
            cond = COND_OFF_COURSE;
        end else if (stab_hit) begin
            cond = COND_STABLE;
        end else begin
            cond = COND_UNKNOWN;
        end
    end

    // Condition stage.
    cond_t  c_cond_reg;
    gains_t c_gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= w_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_free && w_valid) begin
            c_cond_reg  <= cond;
            c_gains_reg <= w_gains;
        end
    end

    // Step speed and gains according to the condition.
    adj_t speed_cur, kp_cur, ki_cur, kd_cur;
    adj_t speed_tgt, kp_tgt, ki_tgt, kd_tgt;
    adj_t speed_adj, kp_adj, ki_adj, kd_adj;
    adj_t speed_sat, kp_sat, ki_sat, kd_sat;

    assign speed_cur = {{(ADJ_W-SPEED_W){c_gains_reg.speed[SPEED_W-1]}}, c_gains_reg.speed};
    assign kp_cur    = {{(ADJ_W-GAIN_W){c_gains_reg.kp[GAIN_W-1]}}, c_gains_reg.kp};
    assign ki_cur    = {{(ADJ_W-GAIN_W){c_gains_reg.ki[GAIN_W-1]}}, c_gains_reg.ki};
    assign kd_cur    = {{(ADJ_W-GAIN_W){c_gains_reg.kd[GAIN_W-1]}}, c_gains_reg.kd};
    assign speed_tgt = {{(ADJ_W-SPEED_W){target_speed_reg[SPEED_W-1]}}, target_speed_reg};
    assign kp_tgt    = {3'b000, target_kp_reg};
    assign ki_tgt    = {3'b000, target_ki_reg};
    assign kd_tgt    = {3'b000, target_kd_reg};

    always_comb begin
        speed_adj = speed_cur;
        kp_adj    = kp_cur;
        ki_adj    = ki_cur;
        kd_adj    = kd_cur;
        case (c_cond_reg)
            COND_ZIGZAG: begin
                kd_adj = kd_cur - ADJ_W'(D_STEP);
            end
            COND_OFF_COURSE: begin
                speed_adj = speed_cur - ADJ_W'(SPEED_STEP);
            end
            COND_STABLE: begin
                speed_adj = toward(speed_cur, speed_tgt, ADJ_W'(SPEED_STEP));
                kp_adj    = toward(kp_cur, kp_tgt, ADJ_W'(P_STEP));
                ki_adj    = toward(ki_cur, ki_tgt, ADJ_W'(I_STEP));
                kd_adj    = toward(kd_cur, kd_tgt, ADJ_W'(D_STEP));
            end
            default: ;
        endcase
    end

    assign speed_sat = saturate(speed_adj, ADJ_W'(SPEED_LIM));
    assign kp_sat    = saturate(kp_adj, ADJ_W'(GAIN_LIM));
    assign ki_sat    = saturate(ki_adj, ADJ_W'(GAIN_LIM));
    assign kd_sat    = saturate(kd_adj, ADJ_W'(GAIN_LIM));

    // Output register.
    logic signed [SPEED_W-1:0] m_speed_reg;
    logic signed [GAIN_W-1:0]  m_kp_reg, m_ki_reg, m_kd_reg;
    cond_t                     m_cond_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && c_valid_reg) begin
            m_speed_reg <= speed_sat[SPEED_W-1:0];
            m_kp_reg    <= kp_sat[GAIN_W-1:0];
            m_ki_reg    <= ki_sat[GAIN_W-1:0];
            m_kd_reg    <= kd_sat[GAIN_W-1:0];
            m_cond_reg  <= c_cond_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_cond_reg, m_kd_reg, m_ki_reg, m_kp_reg, m_speed_reg};

    // No result is offered in the cycle after reset.
    `LGES_ASSERT_RESET(a_reset_clears_out, aclk, (!aresetn |=> !m_tvalid))
    // A sample held in the condition stage keeps its class while blocked.
    `LGES_ASSERT(a_cond_hold, aclk, aresetn, (c_blocked |=> (c_valid_reg && $stable(c_cond_reg))))
    // A classified sample moves to the output whenever the output can load.
    `LGES_ASSERT(a_out_loads, aclk, aresetn, ((c_valid_reg && out_free) |=> m_tvalid))

endmodule

`default_nettype wire
